### design/tsf_pkg.sv
// Package for the triangle scanline fill block: phase and sequencer types.
// No dependencies.
`timescale 1ns / 1ps
package tsf_pkg;
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BOTTOM = 2'd1,
        PH_TOP    = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_SPLIT_MUL,
        ST_SPLIT_DIV,
        ST_SPLIT_WAIT,
        ST_SLOPE,
        ST_SLOPE_WAIT,
        ST_OUT
    } state_t;
endpackage

### design/triangle_scanline_fill_top.sv
// Triangle scanline fill top: sequencer, span stepper and output register.
// Depends on tsf_pkg and tsf_div.
// Load: sort by three compare-exchanges, split multiply, a split division unless the
// triangle is flat, then up to four slope divisions on the one shared divider.
// Advance: one step state, span valid the cycle after; input waits for the span
// transfer before it takes the next item. Reset (rst_n low, async): phase idle,
// all state zero, no output pending.
`timescale 1ns / 1ps
module triangle_scanline_fill_top import tsf_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // x0, y0, x1, y1, x2, y2, fill_color from the low bit up, zero padded
    input  logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // span_y, span_x_lo, span_x_hi, span_color, span_valid, zero padded
    output logic [((3*COORD_BITS+2+33+7)/8)*8-1:0] m_tdata,
    // span_last
    output logic                  m_tlast
);
    localparam int CB  = COORD_BITS;
    localparam int XB  = COORD_BITS + 1;
    localparam int AW  = 2 * COORD_BITS + FRAC_BITS + 4;
    localparam int DB  = COORD_BITS + 2;
    localparam int OW  = ((3*COORD_BITS+2+33+7)/8)*8;

    state_t st_reg, st_next;
    phase_t ph_reg, ph_next;
    logic signed [CB-1:0] vx_reg [3];
    logic signed [CB-1:0] vy_reg [3];
    logic signed [XB-1:0] mx_reg;
    logic [31:0]          col_reg;
    logic signed [CB-1:0] row_reg;
    logic signed [AW-1:0] acc_reg [2];
    logic signed [AW-1:0] slp_reg [4];
    logic [1:0]           sidx_reg;
    logic [1:0]           sortk_reg;
    logic signed [AW-1:0] prod_reg;
    logic [OW-1:0]        od_reg;
    logic                 olast_reg;
    logic                 ov_reg;

    logic                 div_start;
    logic signed [AW-1:0] div_num;
    logic signed [DB-1:0] div_den;
    logic                 div_done;
    logic signed [AW-1:0] div_quo;

    tsf_div #(.NUM_BITS(AW), .DEN_BITS(DB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo)
    );

    logic s_xfer, m_xfer;
    assign s_tready = (st_reg == ST_IDLE) && !ov_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = olast_reg;

    function automatic logic signed [AW-1:0] to_fix(input logic signed [XB:0] v);
        to_fix = AW'(v) <<< FRAC_BITS;
    endfunction

    function automatic logic signed [XB-1:0] ftrunc(input logic signed [AW-1:0] a);
        logic [AW-1:0] m;
        m = a[AW-1] ? AW'(-a) : a;
        m = m >> FRAC_BITS;
        ftrunc = a[AW-1] ? XB'(-m) : XB'(m);
    endfunction

    // slope operands per index
    logic flat_b, flat_t;
    assign flat_b = (vy_reg[1] == vy_reg[2]);
    assign flat_t = !flat_b && (vy_reg[0] == vy_reg[1]);

    logic signed [XB:0] sdx;
    logic signed [DB-1:0] sdy;
    logic                 sact;
    always_comb
    begin
        sdx  = '0;
        sdy  = '0;
        sact = 1'b0;
        case (sidx_reg)
            2'd0:
            begin
                sdx = (XB+1)'(vx_reg[1]) - (XB+1)'(vx_reg[0]);
                sdy = DB'(vy_reg[1]) - DB'(vy_reg[0]);
                sact = !flat_t;
            end
            2'd1:
            begin
                sdx = (flat_b ? (XB+1)'(vx_reg[2]) : (XB+1)'(mx_reg)) - (XB+1)'(vx_reg[0]);
                sdy = flat_b ? DB'(vy_reg[2]) - DB'(vy_reg[0])
                             : DB'(vy_reg[1]) - DB'(vy_reg[0]);
                sact = !flat_t;
            end
            2'd2:
            begin
                sdx = (flat_t ? (XB+1)'(vx_reg[2]) - (XB+1)'(vx_reg[0])
                              : (XB+1)'(vx_reg[2]) - (XB+1)'(vx_reg[1]));
                sdy = flat_t ? DB'(vy_reg[2]) - DB'(vy_reg[0])
                             : DB'(vy_reg[2]) - DB'(vy_reg[1]);
                sact = !flat_b;
            end
            default:
            begin
                sdx = (flat_t ? (XB+1)'(vx_reg[2]) - (XB+1)'(vx_reg[1])
                              : (XB+1)'(vx_reg[2]) - (XB+1)'(mx_reg));
                sdy = DB'(vy_reg[2]) - DB'(vy_reg[1]);
                sact = !flat_b;
            end
        endcase
    end

    always_comb
    begin
        st_next   = st_reg;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (st_reg)
            ST_IDLE:
                if (s_xfer) st_next = s_tuser ? ST_OUT : ST_SORT;
            ST_SORT:
                if (sortk_reg == 2'd2) st_next = ST_SPLIT_MUL;
            ST_SPLIT_MUL:
                st_next = (flat_b || flat_t) ? ST_SLOPE : ST_SPLIT_DIV;
            ST_SPLIT_DIV:
            begin
                div_start = 1'b1;
                div_num   = prod_reg;
                div_den   = DB'(vy_reg[2]) - DB'(vy_reg[0]);
                st_next   = ST_SPLIT_WAIT;
            end
            ST_SPLIT_WAIT:
                if (div_done) st_next = ST_SLOPE;
            ST_SLOPE:
                if (sact && sdy != '0)
                begin
                    div_start = 1'b1;
                    div_num   = to_fix(sdx);
                    div_den   = sdy;
                    st_next   = ST_SLOPE_WAIT;
                end
                else if (sidx_reg == 2'd3)
                    st_next = ST_IDLE;
            ST_SLOPE_WAIT:
                if (div_done) st_next = (sidx_reg == 2'd3) ? ST_IDLE : ST_SLOPE;
            ST_OUT:
                st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    logic signed [XB-1:0] xa, xb;
    assign xa = ftrunc(acc_reg[0]);
    assign xb = ftrunc(acc_reg[1]);

    logic signed [XB-1:0] xlo, xhi;
    assign xlo = (xa < xb) ? xa : xb;
    assign xhi = (xa < xb) ? xb : xa;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            ph_reg    <= PH_IDLE;
            ov_reg    <= 1'b0;
            olast_reg <= 1'b0;
            od_reg    <= '0;
            sidx_reg  <= '0;
            sortk_reg <= '0;
            row_reg   <= '0;
            mx_reg    <= '0;
            col_reg   <= '0;
            prod_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++) acc_reg[i] <= '0;
            for (int i = 0; i < 4; i++) slp_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (m_xfer) ov_reg <= 1'b0;
            else if (st_reg == ST_OUT) ov_reg <= 1'b1;
            case (st_reg)
                ST_IDLE:
                    if (s_xfer && !s_tuser)
                    begin
                        vx_reg[0] <= s_tdata[CB-1:0];
                        vy_reg[0] <= s_tdata[2*CB-1:CB];
                        vx_reg[1] <= s_tdata[3*CB-1:2*CB];
                        vy_reg[1] <= s_tdata[4*CB-1:3*CB];
                        vx_reg[2] <= s_tdata[5*CB-1:4*CB];
                        vy_reg[2] <= s_tdata[6*CB-1:5*CB];
                        col_reg   <= s_tdata[6*CB+31:6*CB];
                        sortk_reg <= '0;
                        sidx_reg  <= '0;
                        ph_reg    <= PH_IDLE;
                        for (int i = 0; i < 4; i++) slp_reg[i] <= '0;
                    end
                ST_SORT:
                begin
                    // one compare-exchange per cycle: (0,1), (1,2), (0,1)
                    if (sortk_reg == 2'd1)
                    begin
                        if (vy_reg[2] < vy_reg[1])
                        begin
                            vx_reg[1] <= vx_reg[2]; vy_reg[1] <= vy_reg[2];
                            vx_reg[2] <= vx_reg[1]; vy_reg[2] <= vy_reg[1];
                        end
                    end
                    else if (vy_reg[1] < vy_reg[0])
                    begin
                        vx_reg[0] <= vx_reg[1]; vy_reg[0] <= vy_reg[1];
                        vx_reg[1] <= vx_reg[0]; vy_reg[1] <= vy_reg[0];
                    end
                    sortk_reg <= sortk_reg + 1'b1;
                end
                ST_SPLIT_MUL:
                begin
                    prod_reg <= AW'((DB'(vx_reg[2]) - DB'(vx_reg[0]))
                                  * (DB'(vy_reg[1]) - DB'(vy_reg[0])));
                    if (flat_b)
                    begin
                        mx_reg  <= XB'(vx_reg[2]);
                        row_reg <= vy_reg[0];
                        ph_reg  <= PH_BOTTOM;
                        acc_reg[0] <= to_fix((XB+1)'(vx_reg[0]));
                        acc_reg[1] <= to_fix((XB+1)'(vx_reg[0]));
                    end
                    else if (flat_t)
                    begin
                        mx_reg  <= XB'(vx_reg[1]);
                        row_reg <= vy_reg[2];
                        ph_reg  <= PH_TOP;
                        acc_reg[0] <= to_fix((XB+1)'(vx_reg[2]));
                        acc_reg[1] <= to_fix((XB+1)'(vx_reg[2]));
                    end
                    else
                    begin
                        row_reg <= vy_reg[0];
                        ph_reg  <= PH_BOTTOM;
                        acc_reg[0] <= to_fix((XB+1)'(vx_reg[0]));
                        acc_reg[1] <= to_fix((XB+1)'(vx_reg[0]));
                    end
                end
                ST_SPLIT_WAIT:
                    if (div_done) mx_reg <= XB'(div_quo) + XB'(vx_reg[0]);
                ST_SLOPE:
                    if (!(sact && sdy != '0)) sidx_reg <= sidx_reg + 1'b1;
                ST_SLOPE_WAIT:
                    if (div_done)
                    begin
                        slp_reg[sidx_reg] <= div_quo;
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                ST_OUT:
                begin
                    if (ph_reg inside {PH_BOTTOM, PH_TOP})
                    begin
                        od_reg <= OW'({1'b1, col_reg, xhi, xlo, row_reg});
                        if (ph_reg == PH_BOTTOM)
                        begin
                            if (row_reg >= vy_reg[1])
                            begin
                                if (!flat_b)
                                begin
                                    olast_reg  <= 1'b0;
                                    ph_reg     <= PH_TOP;
                                    row_reg    <= vy_reg[2];
                                    acc_reg[0] <= to_fix((XB+1)'(vx_reg[2]));
                                    acc_reg[1] <= to_fix((XB+1)'(vx_reg[2]));
                                end
                                else
                                begin
                                    ph_reg    <= PH_IDLE;
                                    olast_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                olast_reg  <= 1'b0;
                                acc_reg[0] <= acc_reg[0] + slp_reg[0];
                                acc_reg[1] <= acc_reg[1] + slp_reg[1];
                                row_reg    <= row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (DB'(row_reg) <= DB'(vy_reg[1]) + DB'(1))
                            begin
                                ph_reg    <= PH_IDLE;
                                olast_reg <= 1'b1;
                            end
                            else
                            begin
                                olast_reg  <= 1'b0;
                                acc_reg[0] <= acc_reg[0] - slp_reg[2];
                                acc_reg[1] <= acc_reg[1] - slp_reg[3];
                                row_reg    <= row_reg - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        od_reg    <= '0;
                        olast_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### design/tsf_div.sv
// Shared restoring divider: signed truncating quotient, one bit per cycle.
// Depends on nothing but the parameters passed from the top level.
`timescale 1ns / 1ps
module tsf_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic signed [DEN_BITS-1:0] den,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quo
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
            d_next    = den[DEN_BITS-1] ? DEN_BITS'(-den) : den;
            neg_next  = num[NUM_BITS-1] ^ den[DEN_BITS-1];
            r_next    = '0;
            cnt_next  = CW'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[NUM_BITS-1]} - {2'b00, d_reg};
            if (!trial[DEN_BITS+1])
            begin
                r_next = trial[DEN_BITS:0];
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? NUM_BITS'(-q_reg) : q_reg;
endmodule

### tb/tb_triangle_scanline_fill_top.sv
// Self-checking testbench for triangle_scanline_fill_top: directed table, then random
// triangles under several idle/stall mixes, checked against a span predictor.
// Depends on tsf_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_triangle_scanline_fill_top import tsf_pkg::*; ();

    localparam int  CB      = 12;
    localparam int  FB      = 16;
    localparam bit  FN_LOAD = 1'b0;
    localparam bit  FN_ADV  = 1'b1;

    typedef struct {
        bit                     func;
        logic signed [CB-1:0]   vx [3];
        logic signed [CB-1:0]   vy [3];
        logic [31:0]            color;
    } tri_item_t;

    typedef struct {
        logic signed [CB-1:0]   y;
        logic signed [CB:0]     lo;
        logic signed [CB:0]     hi;
        logic [31:0]            color;
        logic                   valid;
        logic                   last;
    } span_t;

    typedef struct {
        tri_item_t  item;
        bit         typed;
        span_t      span;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tlast;

    triangle_scanline_fill_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state
    int         vtx_x [3];
    int         vtx_y [3];
    int         split_px;
    logic [31:0] tri_color;
    phase_t     tri_phase;
    int         scan_row;
    longint     edge_l;
    longint     edge_r;
    longint     slope_q [4];

    span_t      span_q [$];
    int         errors;
    int         gap_pct;
    int         stall_pct;
    int         hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint to_fixed(int v);
        return longint'(v) * (64'sd1 <<< FB);
    endfunction

    function automatic longint edge_slope(int dx, int dy);
        if (dy == 0)
            return 0;
        return to_fixed(dx) / longint'(dy);
    endfunction

    function automatic int fixed_trunc(longint a);
        if (a < 0)
            return -int'((-a) >>> FB);
        return int'(a >>> FB);
    endfunction

    function automatic void swap_vtx(int a, int b);
        int tx;
        int ty;
        tx = vtx_x[a];
        ty = vtx_y[a];
        vtx_x[a] = vtx_x[b];
        vtx_y[a] = vtx_y[b];
        vtx_x[b] = tx;
        vtx_y[b] = ty;
    endfunction

    function automatic void load_triangle(tri_item_t t);
        longint q;
        for (int i = 0; i < 3; i++)
        begin
            vtx_x[i] = t.vx[i];
            vtx_y[i] = t.vy[i];
        end
        if (vtx_y[1] < vtx_y[0]) swap_vtx(0, 1);
        if (vtx_y[2] < vtx_y[1]) swap_vtx(1, 2);
        if (vtx_y[1] < vtx_y[0]) swap_vtx(0, 1);
        tri_color = t.color;
        for (int i = 0; i < 4; i++)
            slope_q[i] = 0;
        if (vtx_y[1] == vtx_y[2])
        begin
            split_px   = vtx_x[2];
            slope_q[0] = edge_slope(vtx_x[1] - vtx_x[0], vtx_y[1] - vtx_y[0]);
            slope_q[1] = edge_slope(vtx_x[2] - vtx_x[0], vtx_y[2] - vtx_y[0]);
            edge_l     = to_fixed(vtx_x[0]);
            scan_row   = vtx_y[0];
            tri_phase  = PH_BOTTOM;
        end
        else if (vtx_y[0] == vtx_y[1])
        begin
            split_px   = vtx_x[1];
            slope_q[2] = edge_slope(vtx_x[2] - vtx_x[0], vtx_y[2] - vtx_y[0]);
            slope_q[3] = edge_slope(vtx_x[2] - vtx_x[1], vtx_y[2] - vtx_y[1]);
            edge_l     = to_fixed(vtx_x[2]);
            scan_row   = vtx_y[2];
            tri_phase  = PH_TOP;
        end
        else
        begin
            q = (longint'(vtx_x[2] - vtx_x[0]) * longint'(vtx_y[1] - vtx_y[0]))
                / longint'(vtx_y[2] - vtx_y[0]);
            split_px   = int'(q) + vtx_x[0];
            slope_q[0] = edge_slope(vtx_x[1] - vtx_x[0], vtx_y[1] - vtx_y[0]);
            slope_q[1] = edge_slope(split_px - vtx_x[0], vtx_y[1] - vtx_y[0]);
            slope_q[2] = edge_slope(vtx_x[2] - vtx_x[1], vtx_y[2] - vtx_y[1]);
            slope_q[3] = edge_slope(vtx_x[2] - split_px, vtx_y[2] - vtx_y[1]);
            edge_l     = to_fixed(vtx_x[0]);
            scan_row   = vtx_y[0];
            tri_phase  = PH_BOTTOM;
        end
        edge_r = edge_l;
    endfunction

    function automatic span_t next_span();
        span_t s;
        int    xa;
        int    xb;
        s = '{default: '0};
        if (tri_phase == PH_IDLE)
            return s;
        xa = fixed_trunc(edge_l);
        xb = fixed_trunc(edge_r);
        s.y     = scan_row;
        s.lo    = (xa < xb) ? xa : xb;
        s.hi    = (xa < xb) ? xb : xa;
        s.color = tri_color;
        s.valid = 1'b1;
        if (tri_phase == PH_BOTTOM)
        begin
            if (scan_row >= vtx_y[1])
            begin
                if (vtx_y[2] != vtx_y[1])
                begin
                    tri_phase = PH_TOP;
                    scan_row  = vtx_y[2];
                    edge_l    = to_fixed(vtx_x[2]);
                    edge_r    = edge_l;
                end
                else
                begin
                    tri_phase = PH_IDLE;
                    s.last    = 1'b1;
                end
            end
            else
            begin
                edge_l   += slope_q[0];
                edge_r   += slope_q[1];
                scan_row += 1;
            end
        end
        else if (scan_row <= vtx_y[1] + 1)
        begin
            tri_phase = PH_IDLE;
            s.last    = 1'b1;
        end
        else
        begin
            edge_l   -= slope_q[2];
            edge_r   -= slope_q[3];
            scan_row -= 1;
        end
        return s;
    endfunction

    function automatic tri_item_t mk_tri(bit f, int x0, int y0, int x1, int y1,
                                         int x2, int y2, logic [31:0] c);
        tri_item_t t;
        t.func  = f;
        t.vx[0] = x0;
        t.vy[0] = y0;
        t.vx[1] = x1;
        t.vy[1] = y1;
        t.vx[2] = x2;
        t.vy[2] = y2;
        t.color = c;
        return t;
    endfunction

    function automatic tri_item_t adv_item();
        tri_item_t t;
        t = mk_tri(FN_ADV, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
        return t;
    endfunction

    function automatic span_t mk_span(int y, int lo, int hi, logic [31:0] c,
                                      bit v, bit l);
        span_t s;
        s.y     = y;
        s.lo    = lo;
        s.hi    = hi;
        s.color = c;
        s.valid = v;
        s.last  = l;
        return s;
    endfunction

    // sends one item; predicts at the accepting edge
    task automatic send_item(tri_item_t t, bit typed, span_t typed_span);
        bit    rdy;
        span_t s;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.func;
        s_tdata  <= {t.color, t.vy[2], t.vx[2], t.vy[1], t.vx[1], t.vy[0], t.vx[0]};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        if (t.func == FN_LOAD)
            load_triangle(t);
        else
        begin
            s = next_span();
            span_q.push_back(typed ? typed_span : s);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic tri_item_t rand_load();
        int spread;
        int base;
        int ys [3];
        spread = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(12);
        base = $urandom_range(0, 4095 - spread) - 2048;
        for (int i = 0; i < 3; i++)
            ys[i] = base + $urandom_range(spread);
        case ($urandom_range(7))
            0: ys[1] = ys[0];
            1: ys[2] = ys[1];
            2: ys[2] = ys[0];
            default: ;
        endcase
        return mk_tri(FN_LOAD, $urandom, ys[0], $urandom, ys[1], $urandom, ys[2],
                      $urandom);
    endfunction

    // receiver side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(negedge clk)
    begin
        span_t got;
        span_t exp_s;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.y     = m_tdata[11:0];
            got.lo    = m_tdata[24:12];
            got.hi    = m_tdata[37:25];
            got.color = m_tdata[69:38];
            got.valid = m_tdata[70];
            got.last  = m_tlast;
            if (span_q.size() == 0)
            begin
                $display("%0t: span transfer with nothing expected: y=%0d lo=%0d hi=%0d",
                         $time, got.y, got.lo, got.hi);
                errors++;
            end
            else
            begin
                exp_s = span_q.pop_front();
                if (got.y !== exp_s.y)
                begin
                    $display("%0t: span_y exp %0d got %0d", $time, exp_s.y, got.y);
                    errors++;
                end
                if (got.lo !== exp_s.lo)
                begin
                    $display("%0t: span_x_lo exp %0d got %0d", $time, exp_s.lo, got.lo);
                    errors++;
                end
                if (got.hi !== exp_s.hi)
                begin
                    $display("%0t: span_x_hi exp %0d got %0d", $time, exp_s.hi, got.hi);
                    errors++;
                end
                if (got.color !== exp_s.color)
                begin
                    $display("%0t: span_color exp %h got %h", $time, exp_s.color,
                             got.color);
                    errors++;
                end
                if (got.valid !== exp_s.valid)
                begin
                    $display("%0t: span_valid exp %b got %b", $time, exp_s.valid,
                             got.valid);
                    errors++;
                end
                if (got.last !== exp_s.last)
                begin
                    $display("%0t: span_last exp %b got %b", $time, exp_s.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t  dir [$];
        span_t     none;
        int        sent;
        errors      = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        none        = '{default: '0};
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = 1'b0;
        s_tdata     = '0;
        tri_phase   = PH_IDLE;
        split_px    = 0;
        tri_color   = '0;
        scan_row    = 0;
        edge_l      = 0;
        edge_r      = 0;
        for (int i = 0; i < 3; i++)
        begin
            vtx_x[i] = 0;
            vtx_y[i] = 0;
        end
        for (int i = 0; i < 4; i++)
            slope_q[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance with nothing loaded
        dir.push_back('{adv_item(), 1, mk_span(0, 0, 0, 0, 0, 0)});
        // fully degenerate at the corner of the coordinate range
        dir.push_back('{mk_tri(FN_LOAD, -2048, 2047, -2048, 2047, -2048, 2047,
                              32'hFFFF_FFFF), 0, none});
        dir.push_back('{adv_item(), 1, mk_span(2047, -2048, -2048, 32'hFFFF_FFFF, 1, 1)});
        dir.push_back('{adv_item(), 1, mk_span(0, 0, 0, 0, 0, 0)});
        // flat bottom, widest x
        dir.push_back('{mk_tri(FN_LOAD, 0, 0, -2048, 3, 2047, 3, 32'hA5A5_A5A5), 0, none});
        repeat (4) dir.push_back('{adv_item(), 0, none});
        // flat top at the lowest rows, then one advance past the end
        dir.push_back('{mk_tri(FN_LOAD, -5, -2048, 7, -2048, 1, -2045, 32'h0000_0001),
                        0, none});
        repeat (4) dir.push_back('{adv_item(), 0, none});
        // general triangle given out of order
        dir.push_back('{mk_tri(FN_LOAD, 10, 5, 0, 0, -3, 2, 32'h1234_5678), 0, none});
        repeat (6) dir.push_back('{adv_item(), 0, none});
        // reload while a triangle is active
        dir.push_back('{mk_tri(FN_LOAD, 2047, -1, -2048, 1, 0, 0, 32'h8000_0000), 0, none});
        dir.push_back('{adv_item(), 0, none});
        dir.push_back('{mk_tri(FN_LOAD, 100, 20, -100, 30, 5, 10, 32'h5A5A_5A5A), 0, none});
        dir.push_back('{adv_item(), 0, none});
        foreach (dir[i])
            send_item(dir[i].item, dir[i].typed, dir[i].span);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            sent = 0;
            while (sent < 285)
            begin
                send_item(rand_load(), 0, none);
                sent++;
                // long receiver hold-off so the block backs up
                if (ph == 0 && sent == 150)
                    hold_cycles = 500;
                while (tri_phase != PH_IDLE && $urandom_range(15) != 0)
                begin
                    send_item(adv_item(), 0, none);
                    sent++;
                end
                repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0)
                begin
                    send_item(adv_item(), 0, none);
                    sent++;
                end
                if (ph == 1 && sent > 140 && sent < 160)
                    drain();
            end
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
